### rtl/tlo_pkg.sv
// shared types, widths and command/status structs for the level-order leaf lister
package tlo_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_W    = 4;
    localparam int CNT_W     = 5;

    typedef struct packed {
        logic              left_present;
        logic [NODE_W-1:0] left_index;
        logic              right_present;
        logic [NODE_W-1:0] right_index;
        logic              last_node;
        logic              empty_tree;
    } node_t;

    typedef struct packed {
        logic [NODE_W-1:0] leaf_index;
        logic              tree_empty;
        logic              last_leaf;
    } result_t;

    // child table entry: present flag and node number
    typedef struct packed {
        logic              present;
        logic [NODE_W-1:0] idx;
    } entry_t;

    typedef struct packed {
        logic load_node;
        logic emit_empty;
        logic scan_step;
        logic find_root;
        logic walk_step;
        logic walk_finish;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic queue_empty;
    } status_t;

endpackage

### rtl/tlo_ctrl.sv
// sequencer: load, child scan, root pick and breadth-first walk
module tlo_ctrl
    import tlo_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    last_node,
    input  logic    empty_tree,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_ROOT = 2'd2;
    localparam logic [1:0] ST_WALK = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (empty_tree)
                    begin
                        cmd.emit_empty = 1'b1;
                    end
                    else
                    begin
                        cmd.load_node = 1'b1;
                        if (last_node)
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                cmd.find_root = 1'b1;
                state_next    = ST_WALK;
            end
            ST_WALK:
            begin
                if (status.queue_empty)
                begin
                    cmd.walk_finish = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### rtl/tlo_datapath.sv
// child tables, seen map, walk queue, pending leaf and result register
module tlo_datapath
    import tlo_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  node_t   node,
    input  cmd_t    cmd,
    output status_t status,
    output result_t result,
    output logic    result_valid
);

    entry_t            left_tbl_reg  [MAX_NODES];
    entry_t            right_tbl_reg [MAX_NODES];
    logic [NODE_W-1:0] queue_reg     [MAX_NODES];

    logic [MAX_NODES-1:0] seen_reg, seen_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [NODE_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     tail_reg, tail_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [NODE_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                 res_valid_reg, res_valid_next;
    result_t              res_reg, res_next;

    logic              tbl_we;
    entry_t            new_left, new_right;
    logic              q_we0, q_we1;
    logic [NODE_W-1:0] q_addr0, q_addr1, q_data0, q_data1;

    logic [NODE_W-1:0]    cur_n;
    entry_t               scan_l, scan_r, walk_l, walk_r;
    logic                 has_l, has_r;
    logic [CNT_W-1:0]     tail_mid;
    logic [MAX_NODES-1:0] avail;
    logic [NODE_W-1:0]    root;

    // a child counts only if present and already loaded
    function automatic logic child_ok(entry_t e, logic [CNT_W-1:0] cnt);
        child_ok = e.present && ({1'b0, e.idx} < cnt);
    endfunction

    assign cur_n  = queue_reg[head_reg[NODE_W-1:0]];
    assign scan_l = left_tbl_reg[scan_idx_reg];
    assign scan_r = right_tbl_reg[scan_idx_reg];
    assign walk_l = left_tbl_reg[cur_n];
    assign walk_r = right_tbl_reg[cur_n];
    assign has_l  = child_ok(walk_l, count_reg);
    assign has_r  = child_ok(walk_r, count_reg);

    assign status.scan_last   = ({1'b0, scan_idx_reg} == (count_reg - CNT_W'(1)));
    assign status.queue_empty = (head_reg == tail_reg);

    assign new_left  = '{present: node.left_present,  idx: node.left_index};
    assign new_right = '{present: node.right_present, idx: node.right_index};

    // lowest loaded node not named as a child, node 0 if none
    always_comb
    begin
        for (int k = 0; k < MAX_NODES; k++)
        begin
            avail[k] = !seen_reg[k] && (CNT_W'(k) < count_reg);
        end
        root = '0;
        for (int k = MAX_NODES - 1; k >= 0; k--)
        begin
            if (avail[k])
            begin
                root = NODE_W'(k);
            end
        end
    end

    always_comb
    begin
        seen_next       = seen_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        res_valid_next  = 1'b0;
        res_next        = res_reg;
        tbl_we          = 1'b0;
        q_we0           = 1'b0;
        q_we1           = 1'b0;
        q_addr0         = tail_reg[NODE_W-1:0];
        q_data0         = walk_l.idx;
        tail_mid        = tail_reg;
        q_addr1         = tail_reg[NODE_W-1:0];
        q_data1         = walk_r.idx;

        if (cmd.load_node)
        begin
            if (count_reg != CNT_W'(MAX_NODES))
            begin
                tbl_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
        end

        if (cmd.scan_step)
        begin
            if (child_ok(scan_l, count_reg))
            begin
                seen_next[scan_l.idx] = 1'b1;
            end
            if (child_ok(scan_r, count_reg))
            begin
                seen_next[scan_r.idx] = 1'b1;
            end
            scan_idx_next = scan_idx_reg + NODE_W'(1);
        end

        if (cmd.find_root)
        begin
            q_we0     = 1'b1;
            q_addr0   = '0;
            q_data0   = root;
            head_next = '0;
            tail_next = CNT_W'(1);
        end

        if (cmd.walk_step)
        begin
            head_next = head_reg + CNT_W'(1);
            if (!has_l && !has_r)
            begin
                if (pend_valid_reg)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '{leaf_index: pend_idx_reg, tree_empty: 1'b0,
                                       last_leaf: 1'b0};
                end
                pend_valid_next = 1'b1;
                pend_idx_next   = cur_n;
            end
            // up to two pushes, each dropped once the queue is full
            if (has_l && (tail_reg != CNT_W'(MAX_NODES)))
            begin
                q_we0    = 1'b1;
                tail_mid = tail_reg + CNT_W'(1);
            end
            q_addr1 = tail_mid[NODE_W-1:0];
            if (has_r && (tail_mid != CNT_W'(MAX_NODES)))
            begin
                q_we1     = 1'b1;
                tail_next = tail_mid + CNT_W'(1);
            end
            else
            begin
                tail_next = tail_mid;
            end
        end

        if (cmd.walk_finish)
        begin
            if (pend_valid_reg)
            begin
                res_valid_next = 1'b1;
                res_next       = '{leaf_index: pend_idx_reg, tree_empty: 1'b0,
                                   last_leaf: 1'b1};
            end
        end

        if (cmd.emit_empty)
        begin
            res_valid_next = 1'b1;
            res_next       = '{leaf_index: '0, tree_empty: 1'b1, last_leaf: 1'b1};
        end

        if (cmd.walk_finish || cmd.emit_empty)
        begin
            seen_next       = '0;
            count_next      = '0;
            scan_idx_next   = '0;
            head_next       = '0;
            tail_next       = '0;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= '0;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            seen_reg       <= seen_next;
            count_reg      <= count_next;
            scan_idx_reg   <= scan_idx_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        res_reg      <= res_next;
        if (tbl_we)
        begin
            left_tbl_reg[count_reg[NODE_W-1:0]]  <= new_left;
            right_tbl_reg[count_reg[NODE_W-1:0]] <= new_right;
        end
        if (q_we0)
        begin
            queue_reg[q_addr0] <= q_data0;
        end
        if (q_we1)
        begin
            queue_reg[q_addr1] <= q_data1;
        end
    end

    assign result       = res_reg;
    assign result_valid = res_valid_reg;

endmodule

### rtl/tree_leaves_level_order.sv
// top level of the breadth-first leaf lister
// Nodes are transferred one per cycle while busy is low, numbered from 0 in
// arrival order; up to 16 are kept and later ones are dropped. The node with
// last_node set starts the walk and raises busy: the block first scans the
// child tables, then picks the root, then dequeues the nodes of the
// breadth-first walk in turn and ends with one closing step. A well-formed
// tree dequeues each node once; malformed links can queue up to 16 nodes.
// The scan and the walk each handle one table entry per cycle. Leaves come out
// in level order, left to right, each on result for exactly one cycle with
// result_valid high; the receiver cannot stall, so it must take every
// transfer as it appears. last_leaf marks the final leaf of a tree. A node
// transfer with empty_tree set yields one marker (tree_empty and last_leaf
// high, leaf_index zero) in the next cycle and busy never rises.
module tree_leaves_level_order
    import tlo_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  node_t   node,
    output result_t result,
    output logic    result_valid
);

    cmd_t    cmd;
    status_t status;

    // sequencer decides each cycle's single operation
    tlo_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .last_node  (node.last_node),
        .empty_tree (node.empty_tree),
        .status     (status),
        .cmd        (cmd),
        .busy       (busy)
    );

    // tables, queue and the one-deep pending leaf that lets last_leaf be known
    tlo_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .node         (node),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

### rtl/tlo_checker.sv
// port-level checks for the leaf lister, bound to the top level
module tlo_checker
    import tlo_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input node_t   node,
    input result_t result,
    input logic    result_valid
);

    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && node.empty_tree) |=>
        (result_valid && result.tree_empty && result.last_leaf && !busy))
        else $error("empty tree transfer did not give a marker");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.tree_empty) |-> (result.leaf_index == '0))
        else $error("empty marker carries a leaf index");

    a_walk_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !node.empty_tree && node.last_node) |=> busy)
        else $error("last node did not start the walk");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !node.empty_tree && !node.last_node) |=>
        (!result_valid && !busy))
        else $error("plain node transfer produced output or busy");

endmodule

bind tree_leaves_level_order tlo_checker u_checker (.*);
